/* design/vpcp_pkg.sv */
// ----------------------------------------------------------------------------
// Vector picture command parser package
// Shared widths, request codes, result kinds and the queue entry type.
// ----------------------------------------------------------------------------
package vpcp_pkg;

    localparam int BYTE_W             = 8;
    localparam int OUT_COORD_W        = 10;
    localparam int KIND_W             = 3;
    localparam int TARGET_W           = 2;
    localparam int COORD_BITS_DEFAULT = 10;
    localparam int COORD_BITS_MAX     = 16;
    localparam int QUEUE_DEPTH        = 2;
    localparam int OP_W               = 4;

    // Requests passed from the front to the back
    localparam logic [OP_W-1:0] OP_SET_VIS   = 4'd0;
    localparam logic [OP_W-1:0] OP_CLR_VIS   = 4'd1;
    localparam logic [OP_W-1:0] OP_SET_PRI   = 4'd2;
    localparam logic [OP_W-1:0] OP_CLR_PRI   = 4'd3;
    localparam logic [OP_W-1:0] OP_START_X   = 4'd4;
    localparam logic [OP_W-1:0] OP_START_Y_V = 4'd5;
    localparam logic [OP_W-1:0] OP_START_Y_H = 4'd6;
    localparam logic [OP_W-1:0] OP_CORNER    = 4'd7;
    localparam logic [OP_W-1:0] OP_HOLD      = 4'd8;
    localparam logic [OP_W-1:0] OP_ABS_Y     = 4'd9;
    localparam logic [OP_W-1:0] OP_REL       = 4'd10;
    localparam logic [OP_W-1:0] OP_FILL_Y    = 4'd11;
    localparam logic [OP_W-1:0] OP_PLOT_Y    = 4'd12;
    localparam logic [OP_W-1:0] OP_END       = 4'd13;
    localparam logic [OP_W-1:0] OP_ERR       = 4'd14;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_LINE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FILL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PLOT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

    // Fill targets
    localparam logic [TARGET_W-1:0] TGT_BOTH = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_PRI  = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_VIS  = 2'd2;

    // Stream bytes
    localparam logic [BYTE_W-1:0] BYTE_SET_VIS  = 8'hF0;
    localparam logic [BYTE_W-1:0] BYTE_CLR_VIS  = 8'hF1;
    localparam logic [BYTE_W-1:0] BYTE_SET_PRI  = 8'hF2;
    localparam logic [BYTE_W-1:0] BYTE_CLR_PRI  = 8'hF3;
    localparam logic [BYTE_W-1:0] BYTE_CORNER_Y = 8'hF4;
    localparam logic [BYTE_W-1:0] BYTE_REL      = 8'hF7;
    localparam logic [BYTE_W-1:0] BYTE_FILL     = 8'hF8;
    localparam logic [BYTE_W-1:0] BYTE_PEN      = 8'hF9;
    localparam logic [BYTE_W-1:0] BYTE_PLOT     = 8'hFA;
    localparam logic [BYTE_W-1:0] BYTE_END      = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_OPC_MIN  = 8'hF0;

    localparam int PEN_SKIP_BIT = 5;

    localparam logic [BYTE_W-1:0] PRI_FILL_BG = 8'd4;
    localparam logic [BYTE_W-1:0] VIS_FILL_BG = 8'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
    } vpcp_req_t;

endpackage

/* design/vector_picture_command_parser.sv */
// ----------------------------------------------------------------------------
// Vector picture command parser
// Parses a picture byte stream into line, fill, plot, end and error commands.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, data_byte) takes one picture byte per
// request. The output channel (out_valid, out_ready and the result fields)
// gives at most one drawing command per byte; bytes that only change parser
// state give no result.
// A front end tracks the parse phase and turns each byte into a request; a
// two-entry queue feeds the back end, which holds pen position and colours and
// registers the result. An accepted byte is written to a queue entry and its
// result then to the result register. Throughput is one byte per cycle while
// the receiver takes results.
// When the receiver stalls, the result register holds, the queue fills, and
// in_ready falls once both entries are occupied; nothing is dropped.
// Reset clears the parse phase, colours, pen position and the queue; the block
// is ready for the first byte as soon as reset is released. End of
// picture and unknown opcodes return all state to its reset value.
// ----------------------------------------------------------------------------
module vector_picture_command_parser
    import vpcp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [BYTE_W-1:0]       data_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KIND_W-1:0]       kind,
    output logic [OUT_COORD_W-1:0]  start_x,
    output logic [OUT_COORD_W-1:0]  start_y,
    output logic [OUT_COORD_W-1:0]  end_x,
    output logic [OUT_COORD_W-1:0]  end_y,
    output logic                    visual_on,
    output logic [BYTE_W-1:0]       visual_color,
    output logic                    priority_on,
    output logic [BYTE_W-1:0]       priority_color,
    output logic [TARGET_W-1:0]     fill_target,
    output logic [BYTE_W-1:0]       bad_opcode
);

    logic      fq_valid;
    logic      fq_ready;
    vpcp_req_t fq_req;
    logic      qb_valid;
    logic      qb_ready;
    vpcp_req_t qb_req;

    vpcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .req_valid (fq_valid),
        .req_ready (fq_ready),
        .req       (fq_req)
    );

    vpcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_req   (fq_req),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_req   (qb_req)
    );

    vpcp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (qb_valid),
        .req_ready      (qb_ready),
        .req            (qb_req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .visual_on      (visual_on),
        .visual_color   (visual_color),
        .priority_on    (priority_on),
        .priority_color (priority_color),
        .fill_target    (fill_target),
        .bad_opcode     (bad_opcode)
    );

endmodule

/* design/vpcp_front.sv */
// ----------------------------------------------------------------------------
// Vector picture command parser front end
// Tracks the parse phase and active command and turns each byte into a request.
// ----------------------------------------------------------------------------
module vpcp_front
    import vpcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              req_valid,
    input  logic              req_ready,
    output vpcp_req_t         req
);

    localparam logic [3:0] PH_OPC     = 4'd0;
    localparam logic [3:0] PH_VCOL    = 4'd1;
    localparam logic [3:0] PH_PCOL    = 4'd2;
    localparam logic [3:0] PH_PEN     = 4'd3;
    localparam logic [3:0] PH_START_X = 4'd4;
    localparam logic [3:0] PH_START_Y = 4'd5;
    localparam logic [3:0] PH_LOOP    = 4'd6;
    localparam logic [3:0] PH_ABS_Y   = 4'd7;
    localparam logic [3:0] PH_FILL_Y  = 4'd8;
    localparam logic [3:0] PH_PLOT_X  = 4'd9;
    localparam logic [3:0] PH_PLOT_Y  = 4'd10;

    localparam logic [3:0] CMD_NONE     = 4'h0;
    localparam logic [3:0] CMD_CORNER_Y = 4'h4;
    localparam logic [3:0] CMD_CORNER_X = 4'h5;
    localparam logic [3:0] CMD_ABS      = 4'h6;
    localparam logic [3:0] CMD_REL      = 4'h7;
    localparam logic [3:0] CMD_FILL     = 4'h8;
    localparam logic [3:0] CMD_PLOT     = 4'hA;

    logic [3:0] phase_reg, phase_next;
    logic [3:0] cmd_reg, cmd_next;
    logic       pen_skip_reg, pen_skip_next;

    // opcode decode
    logic [3:0]      opc_phase;
    logic [3:0]      opc_cmd;
    logic            opc_pen_skip;
    logic            opc_push;
    logic [OP_W-1:0] opc_op;

    logic            push;
    logic [OP_W-1:0] push_op;
    logic            take;

    always_comb
    begin
        opc_phase    = PH_OPC;
        opc_cmd      = cmd_reg;
        opc_pen_skip = pen_skip_reg;
        opc_push     = 1'b0;
        opc_op       = OP_ERR;
        case (data_byte)
            BYTE_SET_VIS: opc_phase = PH_VCOL;
            BYTE_CLR_VIS:
            begin
                opc_push = 1'b1;
                opc_op   = OP_CLR_VIS;
            end
            BYTE_SET_PRI: opc_phase = PH_PCOL;
            BYTE_CLR_PRI:
            begin
                opc_push = 1'b1;
                opc_op   = OP_CLR_PRI;
            end
            BYTE_PEN: opc_phase = PH_PEN;
            BYTE_FILL, BYTE_PLOT:
            begin
                opc_cmd   = data_byte[3:0];
                opc_phase = PH_LOOP;
            end
            BYTE_END:
            begin
                opc_push     = 1'b1;
                opc_op       = OP_END;
                opc_cmd      = CMD_NONE;
                opc_pen_skip = 1'b0;
            end
            default:
            begin
                if (data_byte inside {[BYTE_CORNER_Y:BYTE_REL]})
                begin
                    opc_cmd   = data_byte[3:0];
                    opc_phase = PH_START_X;
                end
                else
                begin
                    opc_push     = 1'b1;
                    opc_op       = OP_ERR;
                    opc_cmd      = CMD_NONE;
                    opc_pen_skip = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        pen_skip_next = pen_skip_reg;
        push          = 1'b0;
        push_op       = OP_ERR;
        case (phase_reg)
            PH_VCOL:
            begin
                push       = 1'b1;
                push_op    = OP_SET_VIS;
                phase_next = PH_OPC;
            end
            PH_PCOL:
            begin
                push       = 1'b1;
                push_op    = OP_SET_PRI;
                phase_next = PH_OPC;
            end
            PH_PEN:
            begin
                pen_skip_next = data_byte[PEN_SKIP_BIT];
                phase_next    = PH_OPC;
            end
            PH_START_X:
            begin
                push       = 1'b1;
                push_op    = OP_START_X;
                phase_next = PH_START_Y;
            end
            PH_START_Y:
            begin
                push       = 1'b1;
                push_op    = (cmd_reg == CMD_CORNER_X) ? OP_START_Y_H : OP_START_Y_V;
                phase_next = PH_LOOP;
            end
            PH_ABS_Y:
            begin
                push       = 1'b1;
                push_op    = OP_ABS_Y;
                phase_next = PH_LOOP;
            end
            PH_FILL_Y:
            begin
                push       = 1'b1;
                push_op    = OP_FILL_Y;
                phase_next = PH_LOOP;
            end
            PH_PLOT_X:
            begin
                push       = 1'b1;
                push_op    = OP_HOLD;
                phase_next = PH_PLOT_Y;
            end
            PH_PLOT_Y:
            begin
                push       = 1'b1;
                push_op    = OP_PLOT_Y;
                phase_next = PH_LOOP;
            end
            PH_LOOP:
            begin
                if (data_byte >= BYTE_OPC_MIN)
                begin
                    phase_next    = opc_phase;
                    cmd_next      = opc_cmd;
                    pen_skip_next = opc_pen_skip;
                    push          = opc_push;
                    push_op       = opc_op;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_CORNER_Y, CMD_CORNER_X:
                        begin
                            push    = 1'b1;
                            push_op = OP_CORNER;
                        end
                        CMD_ABS:
                        begin
                            push       = 1'b1;
                            push_op    = OP_HOLD;
                            phase_next = PH_ABS_Y;
                        end
                        CMD_REL:
                        begin
                            push    = 1'b1;
                            push_op = OP_REL;
                        end
                        CMD_FILL:
                        begin
                            push       = 1'b1;
                            push_op    = OP_HOLD;
                            phase_next = PH_FILL_Y;
                        end
                        CMD_PLOT:
                        begin
                            if (pen_skip_reg)
                            begin
                                phase_next = PH_PLOT_X;
                            end
                            else
                            begin
                                push       = 1'b1;
                                push_op    = OP_HOLD;
                                phase_next = PH_PLOT_Y;
                            end
                        end
                        default:
                        begin
                            phase_next    = opc_phase;
                            cmd_next      = opc_cmd;
                            pen_skip_next = opc_pen_skip;
                            push          = opc_push;
                            push_op       = opc_op;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next    = opc_phase;
                cmd_next      = opc_cmd;
                pen_skip_next = opc_pen_skip;
                push          = opc_push;
                push_op       = opc_op;
            end
        endcase
    end

    assign in_ready  = req_ready;
    assign take      = in_valid && in_ready;
    assign req_valid = take && push;
    assign req.op    = push_op;
    assign req.data  = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OPC;
            cmd_reg      <= CMD_NONE;
            pen_skip_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            cmd_reg      <= cmd_next;
            pen_skip_reg <= pen_skip_next;
        end
    end

endmodule

/* design/vpcp_queue.sv */
// ----------------------------------------------------------------------------
// Vector picture command parser request queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module vpcp_queue
    import vpcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  vpcp_req_t wr_req,
    output logic      rd_valid,
    input  logic      rd_ready,
    output vpcp_req_t rd_req
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    vpcp_req_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign rd_req   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_req;
        end
    end

endmodule

/* design/vpcp_back.sv */
// ----------------------------------------------------------------------------
// Vector picture command parser back end
// Holds pen position and colours, carries out requests and registers results.
// ----------------------------------------------------------------------------
module vpcp_back
    import vpcp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  vpcp_req_t               req,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KIND_W-1:0]       kind,
    output logic [OUT_COORD_W-1:0]  start_x,
    output logic [OUT_COORD_W-1:0]  start_y,
    output logic [OUT_COORD_W-1:0]  end_x,
    output logic [OUT_COORD_W-1:0]  end_y,
    output logic                    visual_on,
    output logic [BYTE_W-1:0]       visual_color,
    output logic                    priority_on,
    output logic [BYTE_W-1:0]       priority_color,
    output logic [TARGET_W-1:0]     fill_target,
    output logic [BYTE_W-1:0]       bad_opcode
);

    localparam logic signed [COORD_BITS-1:0] COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic logic signed [COORD_BITS-1:0] byte_coord(input logic [BYTE_W-1:0] b);
        return COORD_BITS'(b);
    endfunction

    function automatic logic [OUT_COORD_W-1:0] out_coord(input logic signed [COORD_BITS-1:0] v);
        logic signed [COORD_BITS_MAX-1:0] w;
        w = COORD_BITS_MAX'(v);
        return w[OUT_COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rel_step(
        input logic signed [COORD_BITS-1:0] cur,
        input logic                         neg,
        input logic [2:0]                   mag
    );
        logic signed [3:0]          d;
        logic signed [COORD_BITS:0] s;
        d = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        s = $signed({cur[COORD_BITS-1], cur}) + (COORD_BITS+1)'(d);
        if (s[COORD_BITS] != s[COORD_BITS-1])
        begin
            return s[COORD_BITS] ? COORD_LO : COORD_HI;
        end
        return s[COORD_BITS-1:0];
    endfunction

    logic                         vis_en_reg, vis_en_next;
    logic [BYTE_W-1:0]            vis_col_reg, vis_col_next;
    logic                         pri_en_reg, pri_en_next;
    logic [BYTE_W-1:0]            pri_col_reg, pri_col_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [BYTE_W-1:0]            held_reg, held_next;
    logic                         corner_reg, corner_next;

    logic                         out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]            kind_reg, kind_next;
    logic [OUT_COORD_W-1:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic [OUT_COORD_W-1:0]       ex_reg, ex_next, ey_reg, ey_next;
    logic                         von_reg, von_next, pon_reg, pon_next;
    logic [BYTE_W-1:0]            vcol_out_reg, vcol_out_next;
    logic [BYTE_W-1:0]            pcol_out_reg, pcol_out_next;
    logic [TARGET_W-1:0]          tgt_reg, tgt_next;
    logic [BYTE_W-1:0]            bad_reg, bad_next;

    logic                         pop;
    logic                         emit;
    logic                         line_go;
    logic signed [COORD_BITS-1:0] line_x, line_y;
    logic                         any_on;

    assign pop       = req_valid && (!out_valid_reg || out_ready);
    assign req_ready = !out_valid_reg || out_ready;
    assign any_on    = vis_en_reg || pri_en_reg;

    always_comb
    begin
        vis_en_next   = vis_en_reg;
        vis_col_next  = vis_col_reg;
        pri_en_next   = pri_en_reg;
        pri_col_next  = pri_col_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        held_next     = held_reg;
        corner_next   = corner_reg;
        line_go       = 1'b0;
        line_x        = cur_x_reg;
        line_y        = cur_y_reg;
        emit          = 1'b0;
        kind_next     = KIND_LINE;
        sx_next       = out_coord(cur_x_reg);
        sy_next       = out_coord(cur_y_reg);
        ex_next       = '0;
        ey_next       = '0;
        von_next      = vis_en_reg;
        vcol_out_next = vis_col_reg;
        pon_next      = pri_en_reg;
        pcol_out_next = pri_col_reg;
        tgt_next      = TGT_BOTH;
        bad_next      = '0;
        case (req.op)
            OP_SET_VIS:
            begin
                vis_col_next = req.data;
                vis_en_next  = 1'b1;
            end
            OP_CLR_VIS: vis_en_next = 1'b0;
            OP_SET_PRI:
            begin
                pri_col_next = req.data;
                pri_en_next  = 1'b1;
            end
            OP_CLR_PRI: pri_en_next = 1'b0;
            OP_START_X: cur_x_next = byte_coord(req.data);
            OP_START_Y_V:
            begin
                cur_y_next  = byte_coord(req.data);
                corner_next = 1'b0;
            end
            OP_START_Y_H:
            begin
                cur_y_next  = byte_coord(req.data);
                corner_next = 1'b1;
            end
            OP_CORNER:
            begin
                line_go     = 1'b1;
                corner_next = !corner_reg;
                if (corner_reg)
                begin
                    line_x = byte_coord(req.data);
                end
                else
                begin
                    line_y = byte_coord(req.data);
                end
            end
            OP_HOLD: held_next = req.data;
            OP_ABS_Y:
            begin
                line_go = 1'b1;
                line_x  = byte_coord(held_reg);
                line_y  = byte_coord(req.data);
            end
            OP_REL:
            begin
                line_go = 1'b1;
                line_x  = rel_step(cur_x_reg, req.data[7], req.data[6:4]);
                line_y  = rel_step(cur_y_reg, req.data[3], req.data[2:0]);
            end
            OP_FILL_Y:
            begin
                kind_next = KIND_FILL;
                sx_next   = out_coord(byte_coord(held_reg));
                sy_next   = out_coord(byte_coord(req.data));
                if (vis_en_reg && pri_en_reg)
                begin
                    emit     = 1'b1;
                    tgt_next = TGT_BOTH;
                end
                else if (pri_en_reg && pri_col_reg != PRI_FILL_BG)
                begin
                    emit     = 1'b1;
                    tgt_next = TGT_PRI;
                end
                else if (vis_en_reg && vis_col_reg != VIS_FILL_BG)
                begin
                    emit     = 1'b1;
                    tgt_next = TGT_VIS;
                end
            end
            OP_PLOT_Y:
            begin
                kind_next = KIND_PLOT;
                sx_next   = out_coord(byte_coord(held_reg));
                sy_next   = out_coord(byte_coord(req.data));
                emit      = any_on;
            end
            OP_END, OP_ERR:
            begin
                emit          = 1'b1;
                kind_next     = (req.op == OP_END) ? KIND_END : KIND_ERR;
                bad_next      = (req.op == OP_END) ? '0 : req.data;
                sx_next       = '0;
                sy_next       = '0;
                von_next      = 1'b0;
                vcol_out_next = '0;
                pon_next      = 1'b0;
                pcol_out_next = '0;
                vis_en_next   = 1'b0;
                vis_col_next  = '0;
                pri_en_next   = 1'b0;
                pri_col_next  = '0;
                cur_x_next    = '0;
                cur_y_next    = '0;
                held_next     = '0;
                corner_next   = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (line_go)
        begin
            emit       = any_on;
            ex_next    = out_coord(line_x);
            ey_next    = out_coord(line_y);
            cur_x_next = line_x;
            cur_y_next = line_y;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_en_reg    <= 1'b0;
            vis_col_reg   <= '0;
            pri_en_reg    <= 1'b0;
            pri_col_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            held_reg      <= '0;
            corner_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                vis_en_reg  <= vis_en_next;
                vis_col_reg <= vis_col_next;
                pri_en_reg  <= pri_en_next;
                pri_col_reg <= pri_col_next;
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                held_reg    <= held_next;
                corner_reg  <= corner_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg     <= kind_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            ex_reg       <= ex_next;
            ey_reg       <= ey_next;
            von_reg      <= von_next;
            vcol_out_reg <= vcol_out_next;
            pon_reg      <= pon_next;
            pcol_out_reg <= pcol_out_next;
            tgt_reg      <= tgt_next;
            bad_reg      <= bad_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign start_x        = sx_reg;
    assign start_y        = sy_reg;
    assign end_x          = ex_reg;
    assign end_y          = ey_reg;
    assign visual_on      = von_reg;
    assign visual_color   = vcol_out_reg;
    assign priority_on    = pon_reg;
    assign priority_color = pcol_out_reg;
    assign fill_target    = tgt_reg;
    assign bad_opcode     = bad_reg;

    a_reset_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (req.op == OP_END || req.op == OP_ERR)) |=>
            (!vis_en_reg && !pri_en_reg && cur_x_reg == '0 && cur_y_reg == '0))
        else $error("state not cleared after end or error");

    a_line_has_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_LINE || kind_reg == KIND_PLOT)) |->
            (von_reg || pon_reg))
        else $error("line or plot emitted with both colours off");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_END) |->
            (sx_reg == '0 && sy_reg == '0 && !von_reg && !pon_reg && bad_reg == '0))
        else $error("end of picture carries stale fields");

    a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("request taken while result is stalled");

endmodule

/* bench/vector_picture_command_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector picture command parser testbench
// Feeds directed and random picture byte streams through the valid/ready
// input, predicts every drawing command in a behavioural parser of its own,
// and checks each command leaving the output channel field by field. Both
// channels idle and stall at random, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
module vector_picture_command_parser_tb
    import vpcp_pkg::*;
();

    localparam int COORD_BITS  = COORD_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 17;
    localparam int DRAIN_DEPTH = 40;

    localparam logic [BYTE_W-1:0] BYTE_CORNER_X    = 8'hF5;
    localparam logic [BYTE_W-1:0] BYTE_ABS         = 8'hF6;
    localparam logic [BYTE_W-1:0] BYTE_UNDEF_FIRST = 8'hFB;
    localparam logic [BYTE_W-1:0] BYTE_UNDEF_LAST  = 8'hFE;

    typedef enum logic [4:0]
    {
        PH_OPCODE,
        PH_VIS_COLOUR,
        PH_PRI_COLOUR,
        PH_PEN,
        PH_START_X,
        PH_START_Y,
        PH_LOOP,
        PH_ABS_Y,
        PH_FILL_Y,
        PH_PLOT_X,
        PH_PLOT_Y
    } parse_phase_t;

    typedef enum logic [3:0]
    {
        CMD_NONE     = 4'h0,
        CMD_CORNER_Y = 4'h4,
        CMD_CORNER_X = 4'h5,
        CMD_ABS      = 4'h6,
        CMD_REL      = 4'h7,
        CMD_FILL     = 4'h8,
        CMD_PLOT     = 4'hA
    } draw_op_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [OUT_COORD_W-1:0] sx;
        logic [OUT_COORD_W-1:0] sy;
        logic [OUT_COORD_W-1:0] ex;
        logic [OUT_COORD_W-1:0] ey;
        logic                   vis_on;
        logic [BYTE_W-1:0]      vis_colour;
        logic                   pri_on;
        logic [BYTE_W-1:0]      pri_colour;
        logic [TARGET_W-1:0]    target;
        logic [BYTE_W-1:0]      bad;
    } draw_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              drain;
    } stream_byte_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      data_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [KIND_W-1:0]      kind;
    logic [OUT_COORD_W-1:0] start_x;
    logic [OUT_COORD_W-1:0] start_y;
    logic [OUT_COORD_W-1:0] end_x;
    logic [OUT_COORD_W-1:0] end_y;
    logic                   visual_on;
    logic [BYTE_W-1:0]      visual_color;
    logic                   priority_on;
    logic [BYTE_W-1:0]      priority_color;
    logic [TARGET_W-1:0]    fill_target;
    logic [BYTE_W-1:0]      bad_opcode;

    // parser shadow state
    parse_phase_t      phase;
    draw_op_t          cmd;
    logic              vis_en;
    logic [BYTE_W-1:0] vis_colour;
    logic              pri_en;
    logic [BYTE_W-1:0] pri_colour;
    logic [BYTE_W-1:0] pen_bits;
    int                pos_x;
    int                pos_y;
    logic [BYTE_W-1:0] held;
    logic              corner_x_turn;

    stream_byte_t stream_q[$];
    draw_cmd_t    expected_cmds[$];
    stream_byte_t pending;
    draw_cmd_t    predicted;
    draw_cmd_t    seen_cmd;

    int  send_wait;
    int  recv_wait;
    int  recv_draw;
    bit  send_burst;
    bit  recv_burst;
    bit  drain_next;
    bit  gen_pen_skip;
    int  bytes_sent;
    int  failures;
    int  cycles;
    int  group_no;
    int  kind_seen [0:7];

    vector_picture_command_parser #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .visual_on      (visual_on),
        .visual_color   (visual_color),
        .priority_on    (priority_on),
        .priority_color (priority_color),
        .fill_target    (fill_target),
        .bad_opcode     (bad_opcode)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_parser();
        phase         = PH_OPCODE;
        cmd           = CMD_NONE;
        vis_en        = 1'b0;
        vis_colour    = '0;
        pri_en        = 1'b0;
        pri_colour    = '0;
        pen_bits      = '0;
        pos_x         = 0;
        pos_y         = 0;
        held          = '0;
        corner_x_turn = 1'b0;
    endfunction

    function automatic int saturate(input int v);
        int hi;
        int lo;
        hi = (1 << (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic draw_cmd_t make_cmd(input logic [KIND_W-1:0] k, input int sx, input int sy,
                                           input int ex, input int ey,
                                           input logic [TARGET_W-1:0] target);
        draw_cmd_t c;
        c            = '0;
        c.kind       = k;
        c.sx         = OUT_COORD_W'(sx);
        c.sy         = OUT_COORD_W'(sy);
        c.ex         = OUT_COORD_W'(ex);
        c.ey         = OUT_COORD_W'(ey);
        c.vis_on     = vis_en;
        c.vis_colour = vis_colour;
        c.pri_on     = pri_en;
        c.pri_colour = pri_colour;
        c.target     = target;
        return c;
    endfunction

    function automatic bit line_to(input int nx, input int ny, output draw_cmd_t c);
        bit drawn;
        c     = '0;
        nx    = saturate(nx);
        ny    = saturate(ny);
        drawn = vis_en || pri_en;
        if (drawn)
            c = make_cmd(KIND_LINE, pos_x, pos_y, nx, ny, '0);
        pos_x = nx;
        pos_y = ny;
        return drawn;
    endfunction

    function automatic bit run_opcode(input logic [BYTE_W-1:0] b, output draw_cmd_t c);
        c     = '0;
        phase = PH_OPCODE;
        case (b)
            BYTE_SET_VIS: phase = PH_VIS_COLOUR;
            BYTE_CLR_VIS: vis_en = 1'b0;
            BYTE_SET_PRI: phase = PH_PRI_COLOUR;
            BYTE_CLR_PRI: pri_en = 1'b0;
            BYTE_CORNER_Y, BYTE_CORNER_X, BYTE_ABS, BYTE_REL:
            begin
                cmd   = draw_op_t'(b[3:0]);
                phase = PH_START_X;
            end
            BYTE_FILL, BYTE_PLOT:
            begin
                cmd   = draw_op_t'(b[3:0]);
                phase = PH_LOOP;
            end
            BYTE_PEN: phase = PH_PEN;
            BYTE_END:
            begin
                c.kind = KIND_END;
                clear_parser();
                return 1'b1;
            end
            default:
            begin
                c.kind = KIND_ERR;
                c.bad  = b;
                clear_parser();
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic bit step_parser(input logic [BYTE_W-1:0] b, output draw_cmd_t c);
        int                  step_x;
        int                  step_y;
        logic [TARGET_W-1:0] target;
        c = '0;
        case (phase)
            PH_VIS_COLOUR:
            begin
                vis_colour = b;
                vis_en     = 1'b1;
                phase      = PH_OPCODE;
            end
            PH_PRI_COLOUR:
            begin
                pri_colour = b;
                pri_en     = 1'b1;
                phase      = PH_OPCODE;
            end
            PH_PEN:
            begin
                pen_bits = b;
                phase    = PH_OPCODE;
            end
            PH_START_X:
            begin
                pos_x = saturate(int'(b));
                phase = PH_START_Y;
            end
            PH_START_Y:
            begin
                pos_y         = saturate(int'(b));
                corner_x_turn = (cmd == CMD_CORNER_X);
                phase         = PH_LOOP;
            end
            PH_LOOP:
            begin
                if (b >= BYTE_OPC_MIN)
                    return run_opcode(b, c);
                case (cmd)
                    CMD_CORNER_Y, CMD_CORNER_X:
                    begin
                        corner_x_turn = !corner_x_turn;
                        if (corner_x_turn)
                            return line_to(pos_x, int'(b), c);
                        return line_to(int'(b), pos_y, c);
                    end
                    CMD_ABS:
                    begin
                        held  = b;
                        phase = PH_ABS_Y;
                    end
                    CMD_REL:
                    begin
                        step_x = int'(b[6:4]);
                        step_y = int'(b[2:0]);
                        if (b[7])
                            step_x = -step_x;
                        if (b[3])
                            step_y = -step_y;
                        return line_to(pos_x + step_x, pos_y + step_y, c);
                    end
                    CMD_FILL:
                    begin
                        held  = b;
                        phase = PH_FILL_Y;
                    end
                    CMD_PLOT:
                    begin
                        if (pen_bits[PEN_SKIP_BIT])
                            phase = PH_PLOT_X;
                        else
                        begin
                            held  = b;
                            phase = PH_PLOT_Y;
                        end
                    end
                    default: return run_opcode(b, c);
                endcase
            end
            PH_ABS_Y:
            begin
                phase = PH_LOOP;
                return line_to(int'(held), int'(b), c);
            end
            PH_FILL_Y:
            begin
                phase = PH_LOOP;
                if (vis_en && pri_en)
                    target = TGT_BOTH;
                else if (pri_en && pri_colour != PRI_FILL_BG)
                    target = TGT_PRI;
                else if (vis_en && vis_colour != VIS_FILL_BG)
                    target = TGT_VIS;
                else
                    return 1'b0;
                c = make_cmd(KIND_FILL, saturate(int'(held)), saturate(int'(b)), 0, 0, target);
                return 1'b1;
            end
            PH_PLOT_X:
            begin
                held  = b;
                phase = PH_PLOT_Y;
            end
            PH_PLOT_Y:
            begin
                phase = PH_LOOP;
                if (!(vis_en || pri_en))
                    return 1'b0;
                c = make_cmd(KIND_PLOT, saturate(int'(held)), saturate(int'(b)), 0, 0, '0);
                return 1'b1;
            end
            default: return run_opcode(b, c);
        endcase
        return 1'b0;
    endfunction

    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] data_low();
        return BYTE_W'($urandom_range(0, BYTE_OPC_MIN - 1));
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] v);
        stream_byte_t item;
        item.value = v;
        item.drain = drain_next;
        drain_next = 1'b0;
        stream_q.push_back(item);
    endtask

    task automatic add_group(input bit long_run);
        int                pick;
        int                n;
        int                mx;
        int                my;
        bit                sx;
        bit                sy;
        bit                along_x;
        bit                neg;
        logic [BYTE_W-1:0] v;
        if (long_run)
        begin
            // steer the pen far enough to hit the coordinate limits
            push_byte(BYTE_REL);
            push_byte(BYTE_W'($urandom_range(0, 31)));
            push_byte(BYTE_W'($urandom_range(0, 31)));
            along_x = 1'($urandom_range(0, 1));
            neg     = 1'($urandom_range(0, 1));
            repeat (100)
            begin
                if (along_x)
                begin
                    sx = neg;
                    mx = neg ? 6 : $urandom_range(6, 7);
                    sy = 1'($urandom_range(0, 1));
                    my = $urandom_range(0, 7);
                end
                else
                begin
                    sy = neg;
                    my = $urandom_range(6, 7);
                    sx = 1'($urandom_range(0, 1));
                    mx = sx ? $urandom_range(0, 6) : $urandom_range(0, 7);
                end
                push_byte({sx, mx[2:0], sy, my[2:0]});
            end
            return;
        end
        pick = $urandom_range(0, 99);
        n    = $urandom_range(1, 6);
        if (pick < 10)
        begin
            push_byte(BYTE_SET_VIS);
            push_byte($urandom_range(0, 3) == 0 ? VIS_FILL_BG : any_byte());
        end
        else if (pick < 14)
            push_byte(BYTE_CLR_VIS);
        else if (pick < 24)
        begin
            push_byte(BYTE_SET_PRI);
            push_byte($urandom_range(0, 3) == 0 ? PRI_FILL_BG : any_byte());
        end
        else if (pick < 28)
            push_byte(BYTE_CLR_PRI);
        else if (pick < 34)
        begin
            v = any_byte();
            gen_pen_skip = v[PEN_SKIP_BIT];
            push_byte(BYTE_PEN);
            push_byte(v);
        end
        else if (pick < 46)
        begin
            push_byte($urandom_range(0, 1) ? BYTE_CORNER_Y : BYTE_CORNER_X);
            push_byte(any_byte());
            push_byte(any_byte());
            repeat (n)
                push_byte(data_low());
        end
        else if (pick < 56)
        begin
            push_byte(BYTE_ABS);
            push_byte(any_byte());
            push_byte(any_byte());
            repeat (n)
            begin
                push_byte(data_low());
                push_byte(any_byte());
            end
        end
        else if (pick < 68)
        begin
            push_byte(BYTE_REL);
            push_byte(any_byte());
            push_byte(any_byte());
            repeat (n)
                push_byte(data_low());
        end
        else if (pick < 78)
        begin
            push_byte(BYTE_FILL);
            repeat (n)
            begin
                push_byte(data_low());
                push_byte(any_byte());
            end
        end
        else if (pick < 88)
        begin
            push_byte(BYTE_PLOT);
            repeat (n)
            begin
                push_byte(data_low());
                if (gen_pen_skip)
                    push_byte(any_byte());
                push_byte(any_byte());
            end
        end
        else if (pick < 92)
        begin
            push_byte(BYTE_END);
            gen_pen_skip = 1'b0;
        end
        else if (pick < 95)
        begin
            push_byte(BYTE_W'($urandom_range(BYTE_UNDEF_FIRST, BYTE_UNDEF_LAST)));
            gen_pen_skip = 1'b0;
        end
        else if (pick < 97)
        begin
            // plain data byte where an opcode is due
            push_byte($urandom_range(0, 1) ? BYTE_CLR_VIS : BYTE_CLR_PRI);
            push_byte(data_low());
            gen_pen_skip = 1'b0;
        end
        else
            push_byte(any_byte());
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                bytes_sent++;
                if (step_parser(data_byte, predicted))
                    expected_cmds.push_back(predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end
                else if (stream_q.size() != 0 &&
                         !(stream_q[0].drain && expected_cmds.size() != 0))
                begin
                    pending = stream_q.pop_front();
                    if ($urandom_range(0, 29) == 0)
                        send_burst = !send_burst;
                    in_valid  <= 1'b1;
                    data_byte <= pending.value;
                    send_wait <= draw_gap(send_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            kind_seen[kind]++;
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected command of kind %0d", kind);
                failures++;
            end
            else
            begin
                seen_cmd = expected_cmds.pop_front();
                check_field("kind", int'(seen_cmd.kind), int'(kind));
                check_field("start_x", int'(seen_cmd.sx), int'(start_x));
                check_field("start_y", int'(seen_cmd.sy), int'(start_y));
                check_field("end_x", int'(seen_cmd.ex), int'(end_x));
                check_field("end_y", int'(seen_cmd.ey), int'(end_y));
                check_field("visual_on", int'(seen_cmd.vis_on), int'(visual_on));
                check_field("visual_color", int'(seen_cmd.vis_colour), int'(visual_color));
                check_field("priority_on", int'(seen_cmd.pri_on), int'(priority_on));
                check_field("priority_color", int'(seen_cmd.pri_colour),
                            int'(priority_color));
                check_field("fill_target", int'(seen_cmd.target), int'(fill_target));
                check_field("bad_opcode", int'(seen_cmd.bad), int'(bad_opcode));
            end
            if ($urandom_range(0, 29) == 0)
                recv_burst = !recv_burst;
            recv_draw = draw_gap(recv_burst);
            recv_wait <= recv_draw;
            out_ready <= (recv_draw == 0);
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            out_ready <= (recv_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("vector_picture_command_parser test failed");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        foreach (kind_seen[k])
            kind_seen[k] = 0;

        // low byte as opcode, then a corner start taking opcode-valued data with no colour
        push_byte(8'h00);
        push_byte(BYTE_CORNER_Y);
        push_byte(8'hF3);
        push_byte(8'hF5);
        push_byte(8'hEF);
        // visual on, relative step with negative zero on both axes
        push_byte(BYTE_SET_VIS);
        push_byte(8'hFF);
        push_byte(BYTE_REL);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h88);
        // priority only with its background colour: fill suppressed
        push_byte(BYTE_SET_PRI);
        push_byte(PRI_FILL_BG);
        push_byte(BYTE_CLR_VIS);
        push_byte(BYTE_FILL);
        push_byte(8'h01);
        push_byte(8'h02);
        // pen skips a pattern byte before each plot point
        push_byte(BYTE_PEN);
        push_byte(8'h20);
        push_byte(BYTE_PLOT);
        push_byte(8'h7E);
        push_byte(8'hF5);
        push_byte(8'h06);
        push_byte(BYTE_UNDEF_FIRST);

        drain_next = 1'b1;
        group_no   = 0;
        while (stream_q.size() < 474)
        begin
            if (group_no == 40)
                drain_next = 1'b1;
            add_group(group_no % 30 == 10);
            group_no++;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stream_q.size() != 0 || in_valid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (DRAIN_DEPTH) @(posedge clk);

        $display("Sent %0d picture bytes in %0d cycles.", bytes_sent, cycles);
        $display("Checked %0d lines, %0d fills, %0d plots, %0d ends, %0d opcode errors.",
                 kind_seen[KIND_LINE], kind_seen[KIND_FILL], kind_seen[KIND_PLOT],
                 kind_seen[KIND_END], kind_seen[KIND_ERR]);
        if (failures == 0)
            $display("vector_picture_command_parser test passed");
        else
            $display("vector_picture_command_parser test failed");
        $finish;
    end

endmodule
